// ===== sv/nev_pkg.sv =====
`timescale 1ns / 1ps
package nev_pkg;

  localparam int COORD_W = 18;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DSQ_W   = SQ_W + 1;
  localparam int RAD_W   = 10;
  localparam int FAC_W   = 4;
  localparam int OUT_W   = FAC_W + RAD_W;
  localparam int OSQ_W   = 2 * OUT_W;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int CNT_W   = 11;
  localparam int HYP_W   = 2;

  localparam int N_DIFF  = 6;
  localparam int D_REF_X = 0;
  localparam int D_REF_Y = 1;
  localparam int D_BOT_X = 2;
  localparam int D_BOT_Y = 3;
  localparam int D_TOP_X = 4;
  localparam int D_TOP_Y = 5;

  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [FAC_W-1:0] FACTOR_RESET = FAC_W'(3);
  localparam logic [CNT_W-1:0] MAX_HITS     = CNT_W'(1024);

  localparam logic [HYP_W-1:0] HYP_INVALID = 2'd0;
  localparam logic [HYP_W-1:0] HYP_BOTTOM  = 2'd1;
  localparam logic [HYP_W-1:0] HYP_TOP     = 2'd2;

  // Classified hit, as handed from the front to the back.
  typedef struct packed {
    logic inc_bot;
    logic inc_top;
    logic last;
  } vote_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic  avail;
    vote_t head;
  } q_head_t;

endpackage

// ===== sv/neighbour_end_vote_core.sv =====
`timescale 1ns / 1ps
// A last hit's vote passes s1, s2, s3, the vote queue and the output register to out_valid.
// Throughput: one hit per cycle while in_stall is low (three-stage squared-distance pipe).
// A stalled result backs up through a four-entry vote queue before in_stall rises.
// Reset is synchronous and active low: it clears all valids, the run state and both counters,
// and sets the distance factor to 3. No clearing pass is needed after reset.
module neighbour_end_vote_core
  import nev_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [FAC_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_ref_x,
  input  logic signed [COORD_W-1:0] in_ref_y,
  input  logic signed [COORD_W-1:0] in_bottom_x,
  input  logic signed [COORD_W-1:0] in_bottom_y,
  input  logic signed [COORD_W-1:0] in_top_x,
  input  logic signed [COORD_W-1:0] in_top_y,
  input  logic signed [COORD_W-1:0] in_hit_x,
  input  logic signed [COORD_W-1:0] in_hit_y,
  input  logic [RAD_W-1:0]          in_hit_radius,
  input  logic                      in_last_hit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [HYP_W-1:0]          out_hypothesis,
  output logic [CNT_W-1:0]          out_bottom_count,
  output logic [CNT_W-1:0]          out_top_count
);

  // The front takes each hit request, forms the six coordinate differences, squares them,
  // and classifies the hit as a neighbour nearer the bottom, nearer the top, or neither.
  // It also tracks run boundaries so that the first hit of a run samples the factor and
  // fixes the outer distance for every later hit of that run.
  logic  q_full, q_push, q_pop;
  vote_t q_data;
  q_head_t q_head;

  nev_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ref_x      (in_ref_x),
    .in_ref_y      (in_ref_y),
    .in_bottom_x   (in_bottom_x),
    .in_bottom_y   (in_bottom_y),
    .in_top_x      (in_top_x),
    .in_top_y      (in_top_y),
    .in_hit_x      (in_hit_x),
    .in_hit_y      (in_hit_y),
    .in_hit_radius (in_hit_radius),
    .in_last_hit   (in_last_hit),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  // The queue holds three-bit classifications, so the front keeps streaming while the
  // result side is stalled.
  nev_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // The back owns the saturating counters. Ordinary hits drain at once; a last hit waits
  // only until the output register is free, then the vote and counts are registered
  // and the counters restart for the next run.
  nev_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hypothesis   (out_hypothesis),
    .out_bottom_count (out_bottom_count),
    .out_top_count    (out_top_count)
  );

endmodule

// ===== sv/nev_front.sv =====
`timescale 1ns / 1ps
module nev_front
  import nev_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [FAC_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_ref_x,
  input  logic signed [COORD_W-1:0] in_ref_y,
  input  logic signed [COORD_W-1:0] in_bottom_x,
  input  logic signed [COORD_W-1:0] in_bottom_y,
  input  logic signed [COORD_W-1:0] in_top_x,
  input  logic signed [COORD_W-1:0] in_top_y,
  input  logic signed [COORD_W-1:0] in_hit_x,
  input  logic signed [COORD_W-1:0] in_hit_y,
  input  logic [RAD_W-1:0]          in_hit_radius,
  input  logic                      in_last_hit,
  input  logic                      q_full,
  output logic                      q_push,
  output vote_t                     q_data
);

  logic [FAC_W-1:0] factor_r;
  logic             run_open_r;
  logic [OUT_W-1:0] outer_run_r;

  logic                     s1_v_r, s2_v_r, s3_v_r;
  logic signed [DIFF_W-1:0] s1_d_r [N_DIFF];
  logic [RAD_W-1:0]         s1_rad_r;
  logic [OUT_W-1:0]         s1_outer_r;
  logic                     s1_last_r;

  logic [SQ_W-1:0]  s2_sq_r [N_DIFF];
  logic [RSQ_W-1:0] s2_rsq_r;
  logic [OSQ_W-1:0] s2_osq_r;
  logic             s2_last_r;

  vote_t s3_vote_r;

  logic                     adv;
  logic                     accept;
  logic [OUT_W-1:0]         outer_nxt;
  logic signed [DIFF_W-1:0] d_nxt [N_DIFF];
  logic [SQ_W-1:0]          sq_nxt [N_DIFF];
  logic signed [2*DIFF_W-1:0] prod [N_DIFF];
  logic [DSQ_W-1:0]         dref, dbot, dtop;
  logic                     neighbour;
  vote_t                    vote_nxt;

  // The whole pipe moves together; it halts only when a finished vote cannot enter the queue.
  assign adv      = !(s3_v_r && q_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign q_push   = s3_v_r && !q_full;
  assign q_data   = s3_vote_r;

  assign outer_nxt = run_open_r ? outer_run_r : OUT_W'(factor_r * in_hit_radius);

  always_comb begin
    d_nxt[D_REF_X] = $signed({in_ref_x[COORD_W-1], in_ref_x})
                   - $signed({in_hit_x[COORD_W-1], in_hit_x});
    d_nxt[D_REF_Y] = $signed({in_ref_y[COORD_W-1], in_ref_y})
                   - $signed({in_hit_y[COORD_W-1], in_hit_y});
    d_nxt[D_BOT_X] = $signed({in_bottom_x[COORD_W-1], in_bottom_x})
                   - $signed({in_hit_x[COORD_W-1], in_hit_x});
    d_nxt[D_BOT_Y] = $signed({in_bottom_y[COORD_W-1], in_bottom_y})
                   - $signed({in_hit_y[COORD_W-1], in_hit_y});
    d_nxt[D_TOP_X] = $signed({in_top_x[COORD_W-1], in_top_x})
                   - $signed({in_hit_x[COORD_W-1], in_hit_x});
    d_nxt[D_TOP_Y] = $signed({in_top_y[COORD_W-1], in_top_y})
                   - $signed({in_hit_y[COORD_W-1], in_hit_y});
  end

  always_comb begin
    for (int i = 0; i < N_DIFF; i++) begin
      prod[i]   = s1_d_r[i] * s1_d_r[i];
      sq_nxt[i] = prod[i][SQ_W-1:0];
    end
  end

  always_comb begin
    dref = {1'b0, s2_sq_r[D_REF_X]} + {1'b0, s2_sq_r[D_REF_Y]};
    dbot = {1'b0, s2_sq_r[D_BOT_X]} + {1'b0, s2_sq_r[D_BOT_Y]};
    dtop = {1'b0, s2_sq_r[D_TOP_X]} + {1'b0, s2_sq_r[D_TOP_Y]};
    neighbour = (dref > DSQ_W'(s2_rsq_r)) && (dref < DSQ_W'(s2_osq_r));
    vote_nxt.inc_bot = neighbour && (dbot < dtop);
    vote_nxt.inc_top = neighbour && (dtop < dbot);
    vote_nxt.last    = s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r   <= FACTOR_RESET;
      run_open_r <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        factor_r <= cfg_wdata;
      end
      if (accept) begin
        run_open_r <= !in_last_hit;
      end
      if (adv) begin
        s1_v_r <= in_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      outer_run_r <= outer_nxt;
    end
    if (adv) begin
      for (int i = 0; i < N_DIFF; i++) begin
        s1_d_r[i]  <= d_nxt[i];
        s2_sq_r[i] <= sq_nxt[i];
      end
      s1_rad_r   <= in_hit_radius;
      s1_outer_r <= outer_nxt;
      s1_last_r  <= in_last_hit;
      s2_rsq_r   <= RSQ_W'(s1_rad_r * s1_rad_r);
      s2_osq_r   <= OSQ_W'(s1_outer_r * s1_outer_r);
      s2_last_r  <= s1_last_r;
      s3_vote_r  <= vote_nxt;
    end
  end

endmodule

// ===== sv/nev_queue.sv =====
`timescale 1ns / 1ps
module nev_queue
  import nev_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  vote_t   push_data,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  vote_t           mem [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == QC_W'(Q_DEPTH));
  assign head.avail = (count_r != '0);
  assign head.head  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= QP_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= QP_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= QC_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= QC_W'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/nev_back.sv =====
`timescale 1ns / 1ps
module nev_back
  import nev_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  q_head_t          q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HYP_W-1:0] out_hypothesis,
  output logic [CNT_W-1:0] out_bottom_count,
  output logic [CNT_W-1:0] out_top_count
);

  logic [CNT_W-1:0] bot_r, top_r, bot_n, top_n;
  logic             out_v_r;
  logic [HYP_W-1:0] hyp_r, hyp_n;
  logic [CNT_W-1:0] obot_r, otop_r;
  logic             out_free;

  assign out_free = !out_v_r || !out_stall;
  assign q_pop    = q_head.avail && (!q_head.head.last || out_free);

  always_comb begin
    bot_n = bot_r;
    top_n = top_r;
    if (q_head.head.inc_bot && (bot_r < MAX_HITS)) begin
      bot_n = CNT_W'(bot_r + 1'b1);
    end
    if (q_head.head.inc_top && (top_r < MAX_HITS)) begin
      top_n = CNT_W'(top_r + 1'b1);
    end
    priority if (bot_n > top_n) begin
      hyp_n = HYP_BOTTOM;
    end else if (top_n > bot_n) begin
      hyp_n = HYP_TOP;
    end else begin
      hyp_n = HYP_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bot_r   <= '0;
      top_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        bot_r <= q_head.head.last ? '0 : bot_n;
        top_r <= q_head.head.last ? '0 : top_n;
      end
      if (q_pop && q_head.head.last) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.head.last) begin
      hyp_r  <= hyp_n;
      obot_r <= bot_n;
      otop_r <= top_n;
    end
  end

  assign out_valid        = out_v_r;
  assign out_hypothesis   = hyp_r;
  assign out_bottom_count = obot_r;
  assign out_top_count    = otop_r;

endmodule

// ===== sv/nev_checker.sv =====
`timescale 1ns / 1ps
module nev_checker
  import nev_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HYP_W-1:0] out_hypothesis,
  input logic [CNT_W-1:0] out_bottom_count,
  input logic [CNT_W-1:0] out_top_count
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hypothesis)
      && $stable(out_bottom_count) && $stable(out_top_count))
    else $error("stalled result changed");

  a_vote_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_hypothesis == HYP_BOTTOM) && (out_bottom_count > out_top_count)) ||
      ((out_hypothesis == HYP_TOP) && (out_top_count > out_bottom_count)) ||
      ((out_hypothesis == HYP_INVALID) && (out_top_count == out_bottom_count)))
    else $error("vote disagrees with counts");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bottom_count <= MAX_HITS) && (out_top_count <= MAX_HITS))
    else $error("count above saturation limit");

endmodule

bind neighbour_end_vote_core nev_checker u_nev_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_hypothesis   (out_hypothesis),
  .out_bottom_count (out_bottom_count),
  .out_top_count    (out_top_count)
);
